### hw/rtl/mapp_pkg.sv
// Shared constants, types and codes for the median/average power protection block.
`default_nettype none
package mapp_pkg;
    localparam int MED_DEPTH = 5;
    localparam int AVG_DEPTH = 8;
    localparam int DATA_W    = 16;
    localparam int MED_IDX_W = (MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1;
    localparam int MED_CNT_W = $clog2(MED_DEPTH + 1);
    localparam int AVG_CNT_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W     = DATA_W + AVG_CNT_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int CFG_CNT_W = 5;
    localparam int RUN_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_ADC    = 2'd1,
        KIND_EVAL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_OC  = 2'd0,
        CAUSE_UV  = 2'd1,
        CAUSE_ADC = 2'd2
    } cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OC_LIMIT   = 3'd0,
        REG_UV_LIMIT   = 3'd1,
        REG_OC_MIN     = 3'd2,
        REG_UV_MIN     = 3'd3,
        REG_STREAK     = 3'd4,
        REG_ADC_NEEDED = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MED,
        ST_AVG,
        ST_DIVS,
        ST_DIV,
        ST_EVAL
    } state_t;

    // Compare flags of one median cell against the broadcast candidate
    typedef struct packed {
        logic lt_v;
        logic eq_v;
        logic lt_c;
        logic eq_c;
    } cmp_t;
endpackage
`default_nettype wire

### hw/rtl/mapp_med_cell.sv
// One median window cell: holds a voltage/current pair, shifts, compares to a candidate.
`default_nettype none
module mapp_med_cell (
    input  wire logic                       clk,
    input  wire logic                       shift,
    input  wire logic [mapp_pkg::DATA_W-1:0] in_v,
    input  wire logic [mapp_pkg::DATA_W-1:0] in_c,
    input  wire logic [mapp_pkg::DATA_W-1:0] cand_v,
    input  wire logic [mapp_pkg::DATA_W-1:0] cand_c,
    output logic      [mapp_pkg::DATA_W-1:0] v,
    output logic      [mapp_pkg::DATA_W-1:0] c,
    output mapp_pkg::cmp_t                   cmp
);
    import mapp_pkg::*;

    logic [DATA_W-1:0] v_reg;
    logic [DATA_W-1:0] c_reg;

    // Entry register, loaded from the neighbor on shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            v_reg <= in_v;
            c_reg <= in_c;
        end
    end

    assign v = v_reg;
    assign c = c_reg;

    // Compare against the candidate
    always_comb
    begin
        cmp.lt_v = v_reg < cand_v;
        cmp.eq_v = v_reg == cand_v;
        cmp.lt_c = c_reg < cand_c;
        cmp.eq_c = c_reg == cand_c;
    end
endmodule
`default_nettype wire

### hw/rtl/mapp_avg_cell.sv
// One moving-average window cell: holds a median pair and passes it on at each push.
`default_nettype none
module mapp_avg_cell (
    input  wire logic                       clk,
    input  wire logic                       shift,
    input  wire logic [mapp_pkg::DATA_W-1:0] in_v,
    input  wire logic [mapp_pkg::DATA_W-1:0] in_c,
    output logic      [mapp_pkg::DATA_W-1:0] v,
    output logic      [mapp_pkg::DATA_W-1:0] c
);
    import mapp_pkg::*;

    logic [DATA_W-1:0] v_reg;
    logic [DATA_W-1:0] c_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            v_reg <= in_v;
            c_reg <= in_c;
        end
    end

    assign v = v_reg;
    assign c = c_reg;
endmodule
`default_nettype wire

### hw/rtl/mapp_div.sv
// Restoring divider, one quotient bit per cycle; quotient holds until the next start.
`default_nettype none
module mapp_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mapp_pkg::SUM_W-1:0]     dividend,
    input  wire logic [mapp_pkg::AVG_CNT_W-1:0] divisor,
    output logic                               busy,
    output logic      [mapp_pkg::DATA_W-1:0]    quotient
);
    import mapp_pkg::*;

    logic [SUM_W-1:0]     quo_reg;
    logic [SUM_W-1:0]     quo_next;
    logic [AVG_CNT_W-1:0] rem_reg;
    logic [AVG_CNT_W-1:0] rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [AVG_CNT_W:0]   trial;
    logic                 take;

    // One trial subtract step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        take     = trial >= {1'b0, divisor};
        rem_next = take ? AVG_CNT_W'(trial - {1'b0, divisor}) : trial[AVG_CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            cnt_reg <= DIV_CNT_W'(SUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg[DATA_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/median_average_power_protect_top.sv
// Top level: median window, moving-average window, dividers and fault evaluation.
//
// Usage: events enter on the in channel (valid/stall), one result per event
// leaves on the out channel (valid/stall). Configuration is a write port
// (cfg_we, cfg_index, cfg_data), to be used while the block is idle; the block itself does not enforce this.
// A sample event (kind 0) shifts the pair into a 5-cell median chain, scans
// the 5 cells for the upper median, pushes the medians into an 8-cell
// average chain, then divides both totals by the fill count in two 20-step
// serial dividers. A sample passes the MED, AVG, DIVS, DIV and EVAL states
// before its result is registered; ADC-failure and evaluate events go
// straight to EVAL, since the averages are kept from the last division.
// One event is in work at a time; in_stall is high from acceptance until the
// result is loaded. The result register lets the next event be taken while
// a result waits; if out_stall holds the result register full, evaluation
// waits and the input stays stalled.
// Reset clears fill counts, totals, averages, streaks and configuration to
// their defaults; the window cells need no reset.
`default_nettype none
module median_average_power_protect_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [15:0]                   voltage_in,
    input  wire logic [15:0]                   current_in,
    input  wire logic                          allow_undervoltage,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [15:0]                   voltage_avg,
    output logic      [15:0]                   current_avg,
    output logic      [4:0]                    samples_held,
    output logic                               fault_fire,
    output logic      [1:0]                    fault_cause,
    input  wire logic                          cfg_we,
    input  wire logic [mapp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mapp_pkg::CFG_DAT_W-1:0] cfg_data
);
    import mapp_pkg::*;

    // Configuration registers
    logic [DATA_W-1:0]    oc_limit_reg;
    logic [DATA_W-1:0]    uv_limit_reg;
    logic [CFG_CNT_W-1:0] oc_min_reg;
    logic [CFG_CNT_W-1:0] uv_min_reg;
    logic [RUN_W-1:0]     streak_reg;
    logic [RUN_W-1:0]     adc_needed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_limit_reg   <= '1;
            uv_limit_reg   <= '0;
            oc_min_reg     <= CFG_CNT_W'(4);
            uv_min_reg     <= CFG_CNT_W'(4);
            streak_reg     <= RUN_W'(3);
            adc_needed_reg <= RUN_W'(3);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_OC_LIMIT:   oc_limit_reg   <= cfg_data[DATA_W-1:0];
                REG_UV_LIMIT:   uv_limit_reg   <= cfg_data[DATA_W-1:0];
                REG_OC_MIN:     oc_min_reg     <= cfg_data[CFG_CNT_W-1:0];
                REG_UV_MIN:     uv_min_reg     <= cfg_data[CFG_CNT_W-1:0];
                REG_STREAK:     streak_reg     <= cfg_data[RUN_W-1:0];
                REG_ADC_NEEDED: adc_needed_reg <= cfg_data[RUN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state
    state_t               state_reg;
    state_t               state_next;
    logic [MED_IDX_W-1:0] k_reg;
    logic [MED_CNT_W-1:0] med_fill_reg;
    logic [AVG_CNT_W-1:0] avg_fill_reg;
    logic [SUM_W-1:0]     vtot_reg;
    logic [SUM_W-1:0]     ctot_reg;
    logic [RUN_W-1:0]     fault_run_reg;
    logic [RUN_W-1:0]     adc_run_reg;
    logic [1:0]           latched_reg;
    logic                 adc_fire_reg;
    logic                 allow_reg;
    logic [DATA_W-1:0]    med_v_reg;
    logic [DATA_W-1:0]    med_c_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_v_reg;
    logic [DATA_W-1:0]    out_c_reg;
    logic [4:0]           out_held_reg;
    logic                 out_fire_reg;
    logic [1:0]           out_cause_reg;

    logic accept;
    logic med_shift;
    logic avg_shift;
    logic div_start;
    logic div_busy_v;
    logic div_busy_c;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    // Median chain
    logic [DATA_W-1:0] med_v [MED_DEPTH];
    logic [DATA_W-1:0] med_c [MED_DEPTH];
    cmp_t              med_cmp [MED_DEPTH];
    logic [DATA_W-1:0] cand_v;
    logic [DATA_W-1:0] cand_c;

    assign cand_v = med_v[k_reg];
    assign cand_c = med_c[k_reg];

    for (genvar j = 0; j < MED_DEPTH; j++)
    begin : g_med
        mapp_med_cell u_cell (
            .clk    (clk),
            .shift  (med_shift),
            .in_v   ((j == 0) ? voltage_in : med_v[(j == 0) ? 0 : j - 1]),
            .in_c   ((j == 0) ? current_in : med_c[(j == 0) ? 0 : j - 1]),
            .cand_v (cand_v),
            .cand_c (cand_c),
            .v      (med_v[j]),
            .c      (med_c[j]),
            .cmp    (med_cmp[j])
        );
    end

    // Stable rank of the candidate among the filled cells
    logic [MED_CNT_W-1:0] rank_v;
    logic [MED_CNT_W-1:0] rank_c;
    logic                 cand_ok;

    always_comb
    begin
        rank_v = '0;
        rank_c = '0;
        for (int j = 0; j < MED_DEPTH; j++)
        begin
            if (MED_CNT_W'(j) < med_fill_reg)
            begin
                if (med_cmp[j].lt_v || (med_cmp[j].eq_v && MED_IDX_W'(j) < k_reg))
                    rank_v = rank_v + 1'b1;
                if (med_cmp[j].lt_c || (med_cmp[j].eq_c && MED_IDX_W'(j) < k_reg))
                    rank_c = rank_c + 1'b1;
            end
        end
        cand_ok = MED_CNT_W'(k_reg) < med_fill_reg;
    end

    // Average chain
    logic [DATA_W-1:0] avg_v [AVG_DEPTH];
    logic [DATA_W-1:0] avg_c [AVG_DEPTH];

    for (genvar j = 0; j < AVG_DEPTH; j++)
    begin : g_avg
        mapp_avg_cell u_cell (
            .clk   (clk),
            .shift (avg_shift),
            .in_v  ((j == 0) ? med_v_reg : avg_v[(j == 0) ? 0 : j - 1]),
            .in_c  ((j == 0) ? med_c_reg : avg_c[(j == 0) ? 0 : j - 1]),
            .v     (avg_v[j]),
            .c     (avg_c[j])
        );
    end

    logic avg_full;
    assign avg_full = avg_fill_reg == AVG_CNT_W'(AVG_DEPTH);

    // Dividers hold the current averages between samples
    logic [DATA_W-1:0] vavg;
    logic [DATA_W-1:0] cavg;

    mapp_div u_div_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vtot_reg),
        .divisor  (avg_fill_reg),
        .busy     (div_busy_v),
        .quotient (vavg)
    );

    mapp_div u_div_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ctot_reg),
        .divisor  (avg_fill_reg),
        .busy     (div_busy_c),
        .quotient (cavg)
    );

    // Fault evaluation
    logic             oc_hit;
    logic             uv_hit;
    logic             eval_bad;
    logic [1:0]       now_cause;
    logic [1:0]       latched_new;
    logic [RUN_W-1:0] run_new;
    logic             streak_fire;
    logic             fire;
    logic [1:0]       cause;

    always_comb
    begin
        oc_hit      = (CFG_CNT_W'(avg_fill_reg) >= oc_min_reg) && (cavg > oc_limit_reg);
        uv_hit      = allow_reg && (CFG_CNT_W'(avg_fill_reg) >= uv_min_reg)
                      && (vavg < uv_limit_reg);
        eval_bad    = oc_hit || uv_hit;
        now_cause   = oc_hit ? CAUSE_OC : CAUSE_UV;
        latched_new = (fault_run_reg == '0) ? now_cause : latched_reg;
        run_new     = (fault_run_reg == '1) ? fault_run_reg : fault_run_reg + 1'b1;
        if (!eval_bad)
            run_new = '0;
        streak_fire = eval_bad && (run_new >= streak_reg);
        fire        = adc_fire_reg || streak_fire;
        if (adc_fire_reg)
            cause = CAUSE_ADC;
        else if (streak_fire)
            cause = latched_new;
        else
            cause = CAUSE_OC;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (kind_t'(kind) == KIND_SAMPLE) ? ST_MED : ST_EVAL;
            ST_MED:
                if (k_reg == MED_IDX_W'(MED_DEPTH - 1))
                    state_next = ST_AVG;
            ST_AVG:
                state_next = ST_DIVS;
            ST_DIVS:
                state_next = ST_DIV;
            ST_DIV:
                if (!div_busy_v && !div_busy_c)
                    state_next = ST_EVAL;
            ST_EVAL:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        med_shift = 1'b0;
        avg_shift = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                med_shift = in_valid && (kind_t'(kind) == KIND_SAMPLE);
            end
            ST_AVG:  avg_shift = 1'b1;
            ST_DIVS: div_start = 1'b1;
            default: ;
        endcase
    end

    // Sequencer and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            med_fill_reg  <= '0;
            avg_fill_reg  <= '0;
            vtot_reg      <= '0;
            ctot_reg      <= '0;
            fault_run_reg <= '0;
            adc_run_reg   <= '0;
            latched_reg   <= CAUSE_OC;
            adc_fire_reg  <= 1'b0;
            allow_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                k_reg        <= '0;
                allow_reg    <= allow_undervoltage;
                adc_fire_reg <= 1'b0;
                if (kind_t'(kind) == KIND_SAMPLE)
                begin
                    adc_run_reg <= '0;
                    if (med_fill_reg != MED_CNT_W'(MED_DEPTH))
                        med_fill_reg <= med_fill_reg + 1'b1;
                end
                else if (kind_t'(kind) == KIND_ADC)
                begin
                    if (adc_run_reg != '1)
                        adc_run_reg <= adc_run_reg + 1'b1;
                    adc_fire_reg <= ((adc_run_reg == '1) ? adc_run_reg
                                     : adc_run_reg + 1'b1) >= adc_needed_reg;
                end
            end
            if (state_reg == ST_MED)
                k_reg <= k_reg + 1'b1;
            if (state_reg == ST_AVG)
            begin
                vtot_reg <= vtot_reg - (avg_full ? SUM_W'(avg_v[AVG_DEPTH-1]) : '0)
                            + SUM_W'(med_v_reg);
                ctot_reg <= ctot_reg - (avg_full ? SUM_W'(avg_c[AVG_DEPTH-1]) : '0)
                            + SUM_W'(med_c_reg);
                if (!avg_full)
                    avg_fill_reg <= avg_fill_reg + 1'b1;
            end
            if (state_reg == ST_EVAL && out_free)
            begin
                fault_run_reg <= run_new;
                latched_reg   <= eval_bad ? latched_new : latched_reg;
            end
        end
    end

    // Median capture during the scan
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MED && cand_ok)
        begin
            if (rank_v == (med_fill_reg >> 1))
                med_v_reg <= cand_v;
            if (rank_c == (med_fill_reg >> 1))
                med_c_reg <= cand_c;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_EVAL && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL && out_free)
        begin
            out_v_reg     <= vavg;
            out_c_reg     <= cavg;
            out_held_reg  <= 5'(avg_fill_reg);
            out_fire_reg  <= fire;
            out_cause_reg <= cause;
        end
    end

    assign out_valid    = out_valid_reg;
    assign voltage_avg  = out_v_reg;
    assign current_avg  = out_c_reg;
    assign samples_held = out_held_reg;
    assign fault_fire   = out_fire_reg;
    assign fault_cause  = out_cause_reg;
endmodule
`default_nettype wire

### hw/rtl/mapp_chk.sv
// Port-level checker for the power protection block, bound to the top level.
`default_nettype none
module mapp_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] voltage_avg,
    input wire logic [15:0] current_avg,
    input wire logic [4:0]  samples_held,
    input wire logic        fault_fire,
    input wire logic [1:0]  fault_cause
);
    // No fault reported means cause zero
    a_cause_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fault_fire |-> fault_cause == 2'd0)
        else $error("fault_cause nonzero without fault");

    // Window never holds more than its depth
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_held <= 5'd8)
        else $error("samples_held out of range");

    // Empty window reports zero averages
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && samples_held == 5'd0 |-> voltage_avg == 16'd0 && current_avg == 16'd0)
        else $error("nonzero average with empty window");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(voltage_avg) && $stable(fault_fire))
        else $error("stalled result changed");
endmodule

bind median_average_power_protect_top mapp_chk u_mapp_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .voltage_avg  (voltage_avg),
    .current_avg  (current_avg),
    .samples_held (samples_held),
    .fault_fire   (fault_fire),
    .fault_cause  (fault_cause)
);
`default_nettype wire
